>>> src/pbs_pkg.sv
// Shared types and constants for the binary64 power-by-squaring block.
// Used by the arithmetic unit and the top level; no dependencies.
package pbs_pkg;

    localparam int EXP_W     = 13;   // signed working exponent, covers every intermediate
    localparam int MANT_W    = 53;
    localparam int PROD_W    = 106;
    localparam int REM_W     = 54;
    localparam int CNT_W     = 6;
    localparam int MUL_STEPS = 4;    // partial products per multiply
    localparam int DIV_STEPS = 55;   // quotient bits per reciprocal
    localparam int HALF_W    = 27;

    localparam logic [63:0] ONE_BITS    = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [10:0] EXP_MAX     = 11'h7FF;

    localparam logic signed [EXP_W-1:0] EXP_BIAS_M1 = 13'sd1022;
    localparam logic signed [EXP_W-1:0] EXP_RCP     = 13'sd2046;
    localparam logic signed [EXP_W-1:0] EXP_FLOOR   = -13'sd60;
    localparam logic signed [EXP_W-1:0] EXP_ONE     = 13'sd1;
    localparam logic signed [EXP_W-1:0] EXP_INF     = 13'sd2047;

    typedef enum logic [1:0] {
        OP_MUL = 2'b01,
        OP_RCP = 2'b10
    } fpu_op_t;

    typedef struct packed {
        logic    start;
        fpu_op_t op;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } fpu_rsp_t;

endpackage

>>> src/pbs_ifs.sv
// Valid/ready channel interfaces for operand and result transfers.
// Stand-alone; no package dependency.
interface pbs_in_if;
    logic               valid;
    logic               ready;
    logic [63:0]        base_bits;
    logic signed [31:0] power;

    modport source (output valid, base_bits, power, input ready);
    modport sink (input valid, base_bits, power, output ready);
endinterface

interface pbs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_bits;

    modport source (output valid, result_bits, input ready);
    modport sink (input valid, result_bits, output ready);
endinterface

>>> src/pbs_fpu.sv
// Iterative binary64 multiply and reciprocal, round to nearest even.
// One 27x27 multiplier, one restoring divide step, one-bit normaliser; uses pbs_pkg.
module pbs_fpu (
    input  logic              clk,
    input  logic              rst_n,
    input  pbs_pkg::fpu_req_t req,
    input  logic [63:0]       opa,
    input  logic [63:0]       opb,
    output pbs_pkg::fpu_rsp_t rsp
);
    import pbs_pkg::*;

    typedef enum logic [5:0] {
        F_IDLE    = 6'b000001,
        F_PRENORM = 6'b000010,
        F_DIV     = 6'b000100,
        F_MUL     = 6'b001000,
        F_NORM    = 6'b010000,
        F_ROUND   = 6'b100000
    } fstate_t;

    fstate_t                  state_reg, state_next;
    logic                     done_reg, done_next;
    logic [63:0]              res_reg, res_next;
    logic                     sign_reg, sign_next;
    logic signed [EXP_W-1:0]  exp_reg, exp_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [MANT_W-1:0]        ma_reg, ma_next;
    logic [MANT_W-1:0]        mb_reg, mb_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [2*HALF_W-1:0]      pp_reg, pp_next;
    logic [1:0]               ppsh_reg, ppsh_next;

    logic                     sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic signed [EXP_W-1:0]  ea_eff, eb_eff;
    logic [HALF_W-1:0]        mx, my;
    logic [PROD_W-1:0]        pp_shifted;
    logic                     ge;
    logic [REM_W-1:0]         diff, rem_n;
    logic [DIV_STEPS-1:0]     q_next;
    logic [MANT_W:0]          mr;
    logic [MANT_W-1:0]        mant_fin;
    logic signed [EXP_W-1:0]  exp_fin;
    logic                     rnd_inc;

    always_comb
    begin
        sa     = opa[63];
        sb     = opb[63];
        a_nan  = (opa[62:52] == EXP_MAX) && (opa[51:0] != '0);
        b_nan  = (opb[62:52] == EXP_MAX) && (opb[51:0] != '0);
        a_inf  = (opa[62:52] == EXP_MAX) && (opa[51:0] == '0);
        b_inf  = (opb[62:52] == EXP_MAX) && (opb[51:0] == '0);
        a_zero = (opa[62:0] == '0);
        b_zero = (opb[62:0] == '0);
        ea_eff = (opa[62:52] == '0) ? EXP_ONE : $signed({2'b00, opa[62:52]});
        eb_eff = (opb[62:52] == '0) ? EXP_ONE : $signed({2'b00, opb[62:52]});
    end

    // partial product operand select: low halves are 27 bits, high halves 26
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    begin mx = ma_reg[26:0];          my = mb_reg[26:0];          end
            2'd1:    begin mx = ma_reg[26:0];          my = {1'b0, mb_reg[52:27]}; end
            2'd2:    begin mx = {1'b0, ma_reg[52:27]}; my = mb_reg[26:0];          end
            default: begin mx = {1'b0, ma_reg[52:27]}; my = {1'b0, mb_reg[52:27]}; end
        endcase
        case (ppsh_reg)
            2'd0:    pp_shifted = PROD_W'(pp_reg);
            2'd1:    pp_shifted = PROD_W'(pp_reg) << HALF_W;
            default: pp_shifted = PROD_W'(pp_reg) << (2 * HALF_W);
        endcase
    end

    always_comb
    begin
        ge     = rem_reg >= {1'b0, ma_reg};
        diff   = rem_reg - {1'b0, ma_reg};
        rem_n  = ge ? diff : rem_reg;
        q_next = {prod_reg[DIV_STEPS-2:0], ge};
    end

    always_comb
    begin
        rnd_inc = prod_reg[52] & ((|prod_reg[51:0]) | prod_reg[53]);
        mr      = {1'b0, prod_reg[105:53]} + (MANT_W+1)'(rnd_inc);
        if (mr[MANT_W])
        begin
            mant_fin = mr[MANT_W:1];
            exp_fin  = exp_reg + EXP_ONE;
        end
        else
        begin
            mant_fin = mr[MANT_W-1:0];
            exp_fin  = exp_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        sign_next  = sign_reg;
        exp_next   = exp_reg;
        prod_next  = prod_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        pp_next    = pp_reg;
        ppsh_next  = ppsh_reg;

        unique case (state_reg)
            F_IDLE:
            begin
                if (req.start)
                begin
                    if (req.op == OP_RCP)
                    begin
                        sign_next = sa;
                        if (a_nan)
                        begin
                            res_next  = opa | QUIET_BIT;
                            done_next = 1'b1;
                        end
                        else if (a_zero)
                        begin
                            res_next  = {sa, EXP_MAX, 52'b0};
                            done_next = 1'b1;
                        end
                        else if (a_inf)
                        begin
                            res_next  = {sa, 63'b0};
                            done_next = 1'b1;
                        end
                        else
                        begin
                            ma_next    = {opa[62:52] != '0, opa[51:0]};
                            exp_next   = ea_eff;
                            state_next = F_PRENORM;
                        end
                    end
                    else
                    begin
                        sign_next = sa ^ sb;
                        if (a_nan)
                        begin
                            res_next  = opa | QUIET_BIT;
                            done_next = 1'b1;
                        end
                        else if (b_nan)
                        begin
                            res_next  = opb | QUIET_BIT;
                            done_next = 1'b1;
                        end
                        else if ((a_inf && b_zero) || (a_zero && b_inf))
                        begin
                            res_next  = DEFAULT_NAN;
                            done_next = 1'b1;
                        end
                        else if (a_inf || b_inf)
                        begin
                            res_next  = {sa ^ sb, EXP_MAX, 52'b0};
                            done_next = 1'b1;
                        end
                        else if (a_zero || b_zero)
                        begin
                            res_next  = {sa ^ sb, 63'b0};
                            done_next = 1'b1;
                        end
                        else
                        begin
                            ma_next    = {opa[62:52] != '0, opa[51:0]};
                            mb_next    = {opb[62:52] != '0, opb[51:0]};
                            exp_next   = ea_eff + eb_eff - EXP_BIAS_M1;
                            prod_next  = '0;
                            cnt_next   = '0;
                            state_next = F_MUL;
                        end
                    end
                end
            end

            F_PRENORM:
            begin
                // bring a subnormal divisor up to a leading one at the top
                if (ma_reg[MANT_W-1])
                begin
                    exp_next   = EXP_RCP - exp_reg;
                    rem_next   = REM_W'(1) << (MANT_W - 1);
                    prod_next  = '0;
                    cnt_next   = '0;
                    state_next = F_DIV;
                end
                else
                begin
                    ma_next  = {ma_reg[MANT_W-2:0], 1'b0};
                    exp_next = exp_reg - EXP_ONE;
                end
            end

            F_DIV:
            begin
                rem_next = {rem_n[REM_W-2:0], 1'b0};
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    prod_next  = {q_next, 50'b0, |rem_n};
                    state_next = F_NORM;
                end
                else
                begin
                    prod_next = PROD_W'(q_next);
                    cnt_next  = cnt_reg + 1'b1;
                end
            end

            F_MUL:
            begin
                // multiply one step, accumulate the previous step
                if (cnt_reg != CNT_W'(MUL_STEPS))
                begin
                    pp_next = mx * my;
                    case (cnt_reg[1:0])
                        2'd0:    ppsh_next = 2'd0;
                        2'd3:    ppsh_next = 2'd2;
                        default: ppsh_next = 2'd1;
                    endcase
                end
                if (cnt_reg != '0)
                    prod_next = prod_reg + pp_shifted;
                if (cnt_reg == CNT_W'(MUL_STEPS))
                    state_next = F_NORM;
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            F_NORM:
            begin
                if (exp_reg < EXP_FLOOR)
                begin
                    prod_next = {{(PROD_W-1){1'b0}}, |prod_reg};
                    exp_next  = EXP_ONE;
                end
                else if (exp_reg < EXP_ONE)
                begin
                    prod_next = {1'b0, prod_reg[PROD_W-1:2], prod_reg[1] | prod_reg[0]};
                    exp_next  = exp_reg + EXP_ONE;
                end
                else if (!prod_reg[PROD_W-1] && (exp_reg > EXP_ONE))
                begin
                    prod_next = {prod_reg[PROD_W-2:0], 1'b0};
                    exp_next  = exp_reg - EXP_ONE;
                end
                else
                    state_next = F_ROUND;
            end

            F_ROUND:
            begin
                if (exp_fin >= EXP_INF)
                    res_next = {sign_reg, EXP_MAX, 52'b0};
                else if (mant_fin[MANT_W-1])
                    res_next = {sign_reg, exp_fin[10:0], mant_fin[51:0]};
                else
                    res_next = {sign_reg, 11'b0, mant_fin[51:0]};
                done_next  = 1'b1;
                state_next = F_IDLE;
            end

            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        sign_reg <= sign_next;
        exp_reg  <= exp_next;
        prod_reg <= prod_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        pp_reg   <= pp_next;
        ppsh_reg <= ppsh_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

>>> src/float_power_by_squaring.sv
// Channel   | dir | payload                          | transfer when
// operand   | in  | base_bits[63:0], power[31:0] s   | valid && ready
// result    | out | result_bits[63:0]                | valid && ready
//
// One operand at a time; ready is high only while the sequencer is idle.
// A multiply in pbs_fpu forms 4 partial products on one 27x27 multiplier, then
// normalises and rounds; a subnormal operand or result adds one shift step per
// bit shifted. A negative power costs one reciprocal first, by restoring division.
// An item takes at most 61 multiplies and squares. A zero power passes from S_STEP
// straight to S_DONE without a multiply.
// Reset clears the control state only; a stalled result holds in its register.
// Top level of the binary64 power-by-squaring block; uses pbs_pkg, pbs_ifs, pbs_fpu.
module float_power_by_squaring (
    input  logic       clk,
    input  logic       rst_n,
    pbs_in_if.sink     operand,
    pbs_out_if.source  result
);
    import pbs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_RCP      = 7'b0000010,
        S_RCP_WAIT = 7'b0000100,
        S_STEP     = 7'b0001000,
        S_MUL_WAIT = 7'b0010000,
        S_SQ_WAIT  = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] base_reg, base_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] mag_reg, mag_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;

    fpu_req_t    fpu_req;
    fpu_rsp_t    fpu_rsp;
    logic [63:0] fpu_a;

    pbs_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fpu_req),
        .opa   (fpu_a),
        .opb   (base_reg),
        .rsp   (fpu_rsp)
    );

    always_comb
    begin
        fpu_req.start = 1'b0;
        fpu_req.op    = OP_MUL;
        fpu_a         = base_reg;
        unique case (state_reg)
            S_RCP:
            begin
                fpu_req.start = 1'b1;
                fpu_req.op    = OP_RCP;
            end
            S_STEP:
            begin
                if (mag_reg != '0)
                begin
                    fpu_req.start = 1'b1;
                    if (mag_reg[0])
                        fpu_a = acc_reg;
                end
            end
            S_MUL_WAIT:
            begin
                // square straight after the accumulate unless this was the top bit
                if (fpu_rsp.done && (mag_reg != 32'd1))
                    fpu_req.start = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (operand.valid)
                begin
                    base_next = operand.base_bits;
                    acc_next  = ONE_BITS;
                    if (operand.power[31])
                    begin
                        mag_next   = 32'd0 - operand.power;
                        state_next = S_RCP;
                    end
                    else
                    begin
                        mag_next   = operand.power;
                        state_next = S_STEP;
                    end
                end
            end
            S_RCP:
                state_next = S_RCP_WAIT;
            S_RCP_WAIT:
            begin
                if (fpu_rsp.done)
                begin
                    base_next  = fpu_rsp.res;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (mag_reg == '0)
                    state_next = S_DONE;
                else if (mag_reg[0])
                    state_next = S_MUL_WAIT;
                else
                    state_next = S_SQ_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (fpu_rsp.done)
                begin
                    acc_next = fpu_rsp.res;
                    if (mag_reg == 32'd1)
                    begin
                        mag_next   = '0;
                        state_next = S_STEP;
                    end
                    else
                        state_next = S_SQ_WAIT;
                end
            end
            S_SQ_WAIT:
            begin
                if (fpu_rsp.done)
                begin
                    base_next  = fpu_rsp.res;
                    mag_next   = {1'b0, mag_reg[31:1]};
                    state_next = S_STEP;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        mag_reg      <= mag_next;
        out_data_reg <= out_data_next;
    end

    assign operand.ready      = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.result_bits = out_data_reg;

endmodule
